/* rtl/lxc_pkg.sv */
`timescale 1ns / 1ps
package lxc_pkg;

  // Field widths
  localparam int LIGHT_W   = 15;
  localparam int UV_W      = 17;
  localparam int XZ_W      = 24;
  localparam int Y_W       = 17;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 2;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_WHITE_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WHITE_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WHITE_Z = 2'd2;

  // D65 white after reset
  localparam logic [CFG_W-1:0] WHITE_X_RST = 16'd15573;
  localparam logic [CFG_W-1:0] WHITE_Y_RST = 16'd16384;
  localparam logic [CFG_W-1:0] WHITE_Z_RST = 16'd17840;

  // Lightness curve constants
  localparam logic [LIGHT_W-1:0] L_KNEE = 15'd2048;
  localparam int L_OFS      = 4096;       // 16 in Q7.8
  localparam int LO_MUL     = 6912;       // 27 * 256
  localparam int KAPPA_NUM  = 24389;
  localparam int LO_RND     = 12194;      // KAPPA_NUM / 2
  localparam int CUBE_SH    = 14;
  localparam int CUBE_RND   = 199794688;  // 2^13 * KAPPA_NUM
  localparam int RECIP_SH   = 45;
  localparam logic [63:0] Y_RECIP = (64'd1 << RECIP_SH) / 64'd24389;
  localparam logic [Y_W-1:0] Y_ONE = 17'd65536;

  // Divider sizes
  localparam int AVR_W = 40;   // |Vr|
  localparam int DEN_W = 42;   // |4 Vr|
  localparam int ABS_W = 45;   // |9 Ur|, |Z term|
  localparam int NUM_W = 63;   // rounded numerator
  localparam int SPLIT = 23;   // low part of the split multiply
  localparam int TW    = DEN_W + XZ_W;  // divider compare width

  localparam logic [XZ_W-1:0] OUT_MAX = 24'h7FFFFF;
  localparam logic [XZ_W-1:0] OUT_MIN = 24'h800000;

  // Front end to divider
  typedef struct packed {
    logic             valid;
    logic             lzero;
    logic             uvzero;
    logic [Y_W-1:0]   y;
    logic             negx;
    logic             negz;
    logic [DEN_W-1:0] den;
    logic [NUM_W-1:0] nx;
    logic [NUM_W-1:0] nz;
  } lxc_mid_t;

  // Side info carried through the divider
  typedef struct packed {
    logic           lzero;
    logic           uvzero;
    logic [Y_W-1:0] y;
    logic           negx;
    logic           negz;
    logic           ovfx;
    logic           ovfz;
  } lxc_tag_t;

  // Divider to output stage
  typedef struct packed {
    logic            valid;
    lxc_tag_t        tag;
    logic [XZ_W-1:0] qx;
    logic [XZ_W-1:0] qz;
  } lxc_dq_t;

endpackage

/* rtl/lxc_if.sv */
`timescale 1ns / 1ps
// L*u*v* input channel
interface lxc_luv_if;
  logic                                 valid;
  logic                                 ready;
  logic        [lxc_pkg::LIGHT_W-1:0]   lightness;
  logic signed [lxc_pkg::UV_W-1:0]      u_star;
  logic signed [lxc_pkg::UV_W-1:0]      v_star;
  modport source (output valid, lightness, u_star, v_star, input ready);
  modport sink   (input valid, lightness, u_star, v_star, output ready);
endinterface

// XYZ result channel
interface lxc_xyz_if;
  logic                              valid;
  logic                              ready;
  logic signed [lxc_pkg::XZ_W-1:0]   x_value;
  logic        [lxc_pkg::Y_W-1:0]    y_value;
  logic signed [lxc_pkg::XZ_W-1:0]   z_value;
  logic                              clipped;
  modport source (output valid, x_value, y_value, z_value, clipped, input ready);
  modport sink   (input valid, x_value, y_value, z_value, clipped, output ready);
endinterface

// Register write channel
interface lxc_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [lxc_pkg::CFG_IDX_W-1:0]    index;
  logic [lxc_pkg::CFG_W-1:0]        data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

/* rtl/lxc_front.sv */
`timescale 1ns / 1ps
// Front end: Y curve, Ur/Vr, X/Z numerators, eight stages
module lxc_front (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             en_i,
  input  logic                             in_valid_i,
  input  logic        [lxc_pkg::LIGHT_W-1:0] lightness_i,
  input  logic signed [lxc_pkg::UV_W-1:0]    u_star_i,
  input  logic signed [lxc_pkg::UV_W-1:0]    v_star_i,
  input  logic        [lxc_pkg::CFG_W-1:0]   white_x_i,
  input  logic        [lxc_pkg::CFG_W-1:0]   white_y_i,
  input  logic        [lxc_pkg::CFG_W-1:0]   white_z_i,
  output lxc_pkg::lxc_mid_t                  mid_o
);
  import lxc_pkg::*;

  logic [8:1] v_q;

  // Stage 1: white derived terms
  logic [20:0] d_c;
  logic [21:0] kx_c;
  logic [22:0] ky_c;
  logic [26:0] kd_c;
  logic [LIGHT_W-1:0] lum1_q;
  logic signed [UV_W-1:0] us1_q, vs1_q;
  logic [20:0] d1_q;
  logic [21:0] kx1_q;
  logic [22:0] ky1_q;
  logic [26:0] kd1_q;

  assign d_c  = 21'(white_x_i) + 21'(white_y_i) * 21'd15 + 21'(white_z_i) * 21'd3;
  assign kx_c = 22'(white_x_i) * 22'd52;
  assign ky_c = 23'(white_y_i) * 23'd117;
  assign kd_c = 27'(d_c) * 27'd52;

  // Stage 2: products
  logic [15:0] n_c;
  logic [15:0] n2_q;
  logic [31:0] sq2_q;
  logic [23:0] nlo2_q;
  logic hi2_q, lz2_q;
  logic signed [38:0] pu_c, pv_c, pu2_q, pv2_q;
  logic [36:0] plx2_q;
  logic [37:0] ply2_q;
  logic [41:0] pld2_q;

  assign n_c  = 16'(lum1_q) + 16'(L_OFS);
  assign pu_c = 39'(us1_q) * 39'($signed({1'b0, d1_q}));
  assign pv_c = 39'(vs1_q) * 39'($signed({1'b0, d1_q}));

  // Stage 3: cube, Ur, Vr
  logic [47:0] cube3_q;
  logic [23:0] nlo3_q;
  logic hi3_q, lz3_q;
  logic signed [40:0] ur3_q, vr3_q;
  logic [41:0] pld3_q;

  // Stage 4: Y numerator, X/Z terms
  logic [31:0] yn_c, yn4_q;
  logic signed [45:0] xt_c, zt_c, xt4_q, zt4_q;
  logic [AVR_W-1:0] avr_c, avr4_q;
  logic vneg4_q, uz4_q, lz4_q;

  assign yn_c = hi3_q ? 32'((cube3_q + 48'(CUBE_RND)) >> CUBE_SH) : 32'(nlo3_q);
  assign xt_c = 46'(ur3_q) * 46'sd9;
  assign zt_c = 46'sd3 * (46'($signed({1'b0, pld3_q})) - 46'(ur3_q))
              - 46'sd20 * 46'(vr3_q);
  assign avr_c = vr3_q[40] ? AVR_W'(-vr3_q) : AVR_W'(vr3_q);

  // Stage 5: reciprocal estimate, magnitudes
  logic [16:0] yest_c, yest5_q;
  logic [31:0] yn5_q;
  logic [ABS_W-1:0] axt5_q, azt5_q;
  logic negx5_q, negz5_q, uz5_q, lz5_q;
  logic [AVR_W-1:0] avr5_q;

  assign yest_c = 17'((64'(yn4_q) * Y_RECIP) >> RECIP_SH);

  // Stage 6: quotient correction and clamp
  logic [31:0] rem_c;
  logic [17:0] yc_c;
  logic [Y_W-1:0] y_c, y6_q;
  logic [ABS_W-1:0] axt6_q, azt6_q;
  logic negx6_q, negz6_q, uz6_q, lz6_q;
  logic [AVR_W-1:0] avr6_q;

  assign rem_c = yn5_q - 32'(yest5_q) * 32'(KAPPA_NUM);
  assign yc_c  = 18'(yest5_q) + 18'(rem_c >= 32'(KAPPA_NUM));
  assign y_c   = (yc_c > 18'(Y_ONE)) ? Y_ONE : Y_W'(yc_c);

  // Stage 7: split multiplies Y * |term|
  logic [39:0] pxl7_q, pzl7_q;
  logic [38:0] pxh7_q, pzh7_q;
  logic [Y_W-1:0] y7_q;
  logic negx7_q, negz7_q, uz7_q, lz7_q;
  logic [AVR_W-1:0] avr7_q;

  // Stage 8: rounded numerators
  logic [NUM_W-1:0] nx8_q, nz8_q;
  logic [DEN_W-1:0] den8_q;
  logic [Y_W-1:0] y8_q;
  logic negx8_q, negz8_q, uz8_q, lz8_q;

  // Valid chain
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[7:1], in_valid_i};
    end
  end

  // Data path
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      lum1_q  <= lightness_i;
      us1_q   <= u_star_i;
      vs1_q   <= v_star_i;
      d1_q    <= d_c;
      kx1_q   <= kx_c;
      ky1_q   <= ky_c;
      kd1_q   <= kd_c;

      n2_q    <= n_c;
      sq2_q   <= 32'(n_c) * 32'(n_c);
      nlo2_q  <= 24'(lum1_q) * 24'(LO_MUL) + 24'(LO_RND);
      hi2_q   <= lum1_q > L_KNEE;
      lz2_q   <= lum1_q == '0;
      pu2_q   <= pu_c;
      pv2_q   <= pv_c;
      plx2_q  <= 37'(lum1_q) * 37'(kx1_q);
      ply2_q  <= 38'(lum1_q) * 38'(ky1_q);
      pld2_q  <= 42'(lum1_q) * 42'(kd1_q);

      cube3_q <= 48'(sq2_q) * 48'(n2_q);
      nlo3_q  <= nlo2_q;
      hi3_q   <= hi2_q;
      lz3_q   <= lz2_q;
      ur3_q   <= 41'(pu2_q) + 41'($signed({1'b0, plx2_q}));
      vr3_q   <= 41'(pv2_q) + 41'($signed({1'b0, ply2_q}));
      pld3_q  <= pld2_q;

      yn4_q   <= yn_c;
      xt4_q   <= xt_c;
      zt4_q   <= zt_c;
      avr4_q  <= avr_c;
      vneg4_q <= vr3_q[40];
      uz4_q   <= (ur3_q == '0) || (vr3_q == '0);
      lz4_q   <= lz3_q;

      yest5_q <= yest_c;
      yn5_q   <= yn4_q;
      axt5_q  <= xt4_q[45] ? ABS_W'(-xt4_q) : ABS_W'(xt4_q);
      azt5_q  <= zt4_q[45] ? ABS_W'(-zt4_q) : ABS_W'(zt4_q);
      negx5_q <= xt4_q[45] ^ vneg4_q;
      negz5_q <= zt4_q[45] ^ vneg4_q;
      uz5_q   <= uz4_q;
      lz5_q   <= lz4_q;
      avr5_q  <= avr4_q;

      y6_q    <= y_c;
      axt6_q  <= axt5_q;
      azt6_q  <= azt5_q;
      negx6_q <= negx5_q;
      negz6_q <= negz5_q;
      uz6_q   <= uz5_q;
      lz6_q   <= lz5_q;
      avr6_q  <= avr5_q;

      pxl7_q  <= 40'(y6_q) * 40'(axt6_q[SPLIT-1:0]);
      pxh7_q  <= 39'(y6_q) * 39'(axt6_q[ABS_W-1:SPLIT]);
      pzl7_q  <= 40'(y6_q) * 40'(azt6_q[SPLIT-1:0]);
      pzh7_q  <= 39'(y6_q) * 39'(azt6_q[ABS_W-1:SPLIT]);
      y7_q    <= y6_q;
      negx7_q <= negx6_q;
      negz7_q <= negz6_q;
      uz7_q   <= uz6_q;
      lz7_q   <= lz6_q;
      avr7_q  <= avr6_q;

      // Add half the divisor (2|Vr|) for round to nearest
      nx8_q   <= (NUM_W'(pxh7_q) << SPLIT) + NUM_W'(pxl7_q) + (NUM_W'(avr7_q) << 1);
      nz8_q   <= (NUM_W'(pzh7_q) << SPLIT) + NUM_W'(pzl7_q) + (NUM_W'(avr7_q) << 1);
      den8_q  <= DEN_W'(avr7_q) << 2;
      y8_q    <= y7_q;
      negx8_q <= negx7_q;
      negz8_q <= negz7_q;
      uz8_q   <= uz7_q;
      lz8_q   <= lz7_q;
    end
  end

  assign mid_o.valid  = v_q[8];
  assign mid_o.lzero  = lz8_q;
  assign mid_o.uvzero = uz8_q;
  assign mid_o.y      = y8_q;
  assign mid_o.negx   = negx8_q;
  assign mid_o.negz   = negz8_q;
  assign mid_o.den    = den8_q;
  assign mid_o.nx     = nx8_q;
  assign mid_o.nz     = nz8_q;

endmodule

/* rtl/lxc_div.sv */
`timescale 1ns / 1ps
// Pipelined restoring divider, one quotient bit per stage, X and Z share the divisor
module lxc_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  lxc_pkg::lxc_mid_t mid_i,
  output lxc_pkg::lxc_dq_t  dq_o
);
  import lxc_pkg::*;

  logic [XZ_W:0]    v_q;
  lxc_tag_t         tag_q [0:XZ_W];
  logic [NUM_W-1:0] rx_q  [0:XZ_W];
  logic [NUM_W-1:0] rz_q  [0:XZ_W];
  logic [DEN_W-1:0] den_q [0:XZ_W];
  logic [XZ_W-1:0]  qx_q  [0:XZ_W];
  logic [XZ_W-1:0]  qz_q  [0:XZ_W];
  logic [TW-1:0]    lim_c;

  // Entry: quotient overflow check against den * 2^24
  assign lim_c = TW'(mid_i.den) << XZ_W;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[XZ_W-1:0], mid_i.valid};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      tag_q[0].lzero  <= mid_i.lzero;
      tag_q[0].uvzero <= mid_i.uvzero;
      tag_q[0].y      <= mid_i.y;
      tag_q[0].negx   <= mid_i.negx;
      tag_q[0].negz   <= mid_i.negz;
      tag_q[0].ovfx   <= TW'(mid_i.nx) >= lim_c;
      tag_q[0].ovfz   <= TW'(mid_i.nz) >= lim_c;
      rx_q[0]         <= mid_i.nx;
      rz_q[0]         <= mid_i.nz;
      den_q[0]        <= mid_i.den;
      qx_q[0]         <= '0;
      qz_q[0]         <= '0;
    end
  end

  // Quotient bit stages, MSB first
  for (genvar k = 0; k < XZ_W; k++) begin : g_step
    logic [TW-1:0] trial_c;
    logic          bx_c, bz_c;

    assign trial_c = TW'(den_q[k]) << (XZ_W - 1 - k);
    assign bx_c    = TW'(rx_q[k]) >= trial_c;
    assign bz_c    = TW'(rz_q[k]) >= trial_c;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        tag_q[k+1] <= tag_q[k];
        den_q[k+1] <= den_q[k];
        rx_q[k+1]  <= bx_c ? NUM_W'(TW'(rx_q[k]) - trial_c) : rx_q[k];
        rz_q[k+1]  <= bz_c ? NUM_W'(TW'(rz_q[k]) - trial_c) : rz_q[k];
        qx_q[k+1]  <= {qx_q[k][XZ_W-2:0], bx_c};
        qz_q[k+1]  <= {qz_q[k][XZ_W-2:0], bz_c};
      end
    end
  end

  assign dq_o.valid = v_q[XZ_W];
  assign dq_o.tag   = tag_q[XZ_W];
  assign dq_o.qx    = qx_q[XZ_W];
  assign dq_o.qz    = qz_q[XZ_W];

endmodule

/* rtl/cie_luv_to_xyz_converter_unit.sv */
`timescale 1ns / 1ps
// Pipeline: 8 front stages, divider entry, 24 divider bit stages, output register.
// Throughput: one beat per cycle; the whole pipeline holds while the output is stalled.
// Reset: clears all stage valid bits and loads the D65 white point.
module cie_luv_to_xyz_converter_unit (
  input  logic      clk_i,
  input  logic      rst_ni,
  lxc_luv_if.sink   in_i,
  lxc_xyz_if.source out_o,
  lxc_cfg_if.sink   cfg_i
);
  import lxc_pkg::*;

  logic [CFG_W-1:0] white_x_q, white_y_q, white_z_q;
  logic             en;
  lxc_mid_t         mid;
  lxc_dq_t          dq;

  logic             out_valid_q;
  logic [XZ_W-1:0]  x_q, z_q;
  logic [Y_W-1:0]   y_q;
  logic             clip_q;

  logic [XZ_W-1:0]  x_c, z_c;
  logic             satx_c, satz_c;

  // White point registers
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      white_x_q <= WHITE_X_RST;
      white_y_q <= WHITE_Y_RST;
      white_z_q <= WHITE_Z_RST;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        REG_WHITE_X: white_x_q <= cfg_i.data;
        REG_WHITE_Y: white_y_q <= cfg_i.data;
        REG_WHITE_Z: white_z_q <= cfg_i.data;
        default: ;
      endcase
    end
  end

  // Pipeline advances unless a result is waiting and the output is not ready
  assign en         = !out_valid_q || out_o.ready;
  assign in_i.ready = en;

  lxc_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (en),
    .in_valid_i  (in_i.valid),
    .lightness_i (in_i.lightness),
    .u_star_i    (in_i.u_star),
    .v_star_i    (in_i.v_star),
    .white_x_i   (white_x_q),
    .white_y_i   (white_y_q),
    .white_z_i   (white_z_q),
    .mid_o       (mid)
  );

  lxc_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .mid_i  (mid),
    .dq_o   (dq)
  );

  // Sign, saturation and zero cases
  always_comb begin
    x_c    = '0;
    z_c    = '0;
    satx_c = 1'b0;
    satz_c = 1'b0;
    if (!dq.tag.lzero && !dq.tag.uvzero) begin
      if (dq.tag.ovfx) begin
        satx_c = 1'b1;
        x_c    = dq.tag.negx ? OUT_MIN : OUT_MAX;
      end else if (dq.tag.negx) begin
        satx_c = dq.qx > OUT_MIN;
        x_c    = satx_c ? OUT_MIN : -dq.qx;
      end else begin
        satx_c = dq.qx > OUT_MAX;
        x_c    = satx_c ? OUT_MAX : dq.qx;
      end
      if (dq.tag.ovfz) begin
        satz_c = 1'b1;
        z_c    = dq.tag.negz ? OUT_MIN : OUT_MAX;
      end else if (dq.tag.negz) begin
        satz_c = dq.qz > OUT_MIN;
        z_c    = satz_c ? OUT_MIN : -dq.qz;
      end else begin
        satz_c = dq.qz > OUT_MAX;
        z_c    = satz_c ? OUT_MAX : dq.qz;
      end
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= dq.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      x_q    <= x_c;
      z_q    <= z_c;
      y_q    <= dq.tag.lzero ? '0 : dq.tag.y;
      clip_q <= satx_c | satz_c;
    end
  end

  assign out_o.valid   = out_valid_q;
  assign out_o.x_value = x_q;
  assign out_o.y_value = y_q;
  assign out_o.z_value = z_q;
  assign out_o.clipped = clip_q;

endmodule
